// ----- design/lant_pkg.sv -----
// Shared types and constants for the Langton's ant grid stepper.
package lant_pkg;

    localparam int POS_W      = 6;
    localparam int HEAD_W     = 2;
    localparam int STEP_W     = 20;
    localparam int SIZE_W     = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BOARD_ROWS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOARD_COLS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ROW     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_COL     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_HEADING = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LIMIT    = 3'd5;

    // headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] board_rows;
        logic [SIZE_W-1:0] board_cols;
        logic [POS_W-1:0]  start_row;
        logic [POS_W-1:0]  start_col;
        logic [HEAD_W-1:0] start_heading;
        logic [STEP_W-1:0] step_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        board_rows:    7'd64,
        board_cols:    7'd64,
        start_row:     6'd0,
        start_col:     6'd0,
        start_heading: 2'd0,
        step_limit:    20'd0
    };

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_EMIT
    } state_t;

endpackage

// ----- design/lant_cfg_regs.sv -----
// Configuration register file of the ant stepper.
module lant_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lant_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lant_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lant_pkg::cfg_t                    cfg
);

    lant_pkg::cfg_t cfg_reg;
    lant_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                lant_pkg::REG_BOARD_ROWS:
                    cfg_next.board_rows = cfg_data[lant_pkg::SIZE_W-1:0];
                lant_pkg::REG_BOARD_COLS:
                    cfg_next.board_cols = cfg_data[lant_pkg::SIZE_W-1:0];
                lant_pkg::REG_START_ROW:
                    cfg_next.start_row = cfg_data[lant_pkg::POS_W-1:0];
                lant_pkg::REG_START_COL:
                    cfg_next.start_col = cfg_data[lant_pkg::POS_W-1:0];
                lant_pkg::REG_START_HEADING:
                    cfg_next.start_heading = cfg_data[lant_pkg::HEAD_W-1:0];
                lant_pkg::REG_STEP_LIMIT:
                    cfg_next.step_limit = cfg_data[lant_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;   // writes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lant_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/lant_cell_ram.sv -----
// One-bit cell memory: one write port, one read port with registered data.
module lant_cell_ram
#(
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem [2**ADDR_W];
    logic rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ----- design/lant_ctrl.sv -----
// Step sequencer: clearing pass, ant position, heading, step count, result register.
module lant_ctrl
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lant_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_restart,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lant_pkg::POS_W-1:0]            out_row,
    output logic [lant_pkg::POS_W-1:0]            out_col,
    output logic [lant_pkg::HEAD_W-1:0]           out_heading,
    output logic                                  out_under,
    output logic [lant_pkg::STEP_W-1:0]           out_step,
    output logic                                  out_done,
    output logic                                  ram_wr_en,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] ram_wr_addr,
    output logic                                  ram_wr_data,
    output logic                                  ram_rd_en,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] ram_rd_addr,
    input  logic                                  ram_rd_data
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int RCMP_W = (ROW_W + 1 > lant_pkg::SIZE_W) ? ROW_W + 1 : lant_pkg::SIZE_W;
    localparam int CCMP_W = (COL_W + 1 > lant_pkg::SIZE_W) ? COL_W + 1 : lant_pkg::SIZE_W;
    localparam int RS_W   = (ROW_W > lant_pkg::POS_W) ? ROW_W : lant_pkg::POS_W;
    localparam int CS_W   = (COL_W > lant_pkg::POS_W) ? COL_W : lant_pkg::POS_W;
    localparam logic [RCMP_W-1:0] MAX_ROWS_C = RCMP_W'(MAX_ROWS);
    localparam logic [CCMP_W-1:0] MAX_COLS_C = CCMP_W'(MAX_COLS);

    lant_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]            row_reg, row_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [lant_pkg::HEAD_W-1:0] dir_reg, dir_next;
    logic [lant_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        done_reg, done_next;
    logic                        fresh_reg, fresh_next;   // result after restart: white cell
    logic                        clr_emit_reg, clr_emit_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;

    logic                        out_valid_reg, out_valid_next;
    logic [lant_pkg::POS_W-1:0]  out_row_reg, out_row_next;
    logic [lant_pkg::POS_W-1:0]  out_col_reg, out_col_next;
    logic [lant_pkg::HEAD_W-1:0] out_heading_reg, out_heading_next;
    logic                        out_under_reg, out_under_next;
    logic [lant_pkg::STEP_W-1:0] out_step_reg, out_step_next;
    logic                        out_done_reg, out_done_next;

    logic              out_free;
    logic              accept;
    logic              limit_hit;
    logic              clr_last;
    logic [RCMP_W-1:0] rows_ext, last_row_w;
    logic [CCMP_W-1:0] cols_ext, last_col_w;
    logic [ROW_W-1:0]  last_row, row_cl, start_row_cl;
    logic [COL_W-1:0]  last_col, col_cl, start_col_cl;
    logic [RS_W-1:0]   srow_ext, lrow_ext;
    logic [CS_W-1:0]   scol_ext, lcol_ext;
    logic [lant_pkg::HEAD_W-1:0] dir_turn, dir_mv;
    logic              at_edge;
    logic [ROW_W-1:0]  row_mv;
    logic [COL_W-1:0]  col_mv;
    logic [ROW_W+lant_pkg::POS_W-1:0] row_wide;
    logic [COL_W+lant_pkg::POS_W-1:0] col_wide;

    // board size in use, as last index
    assign rows_ext = RCMP_W'(cfg.board_rows);
    assign cols_ext = CCMP_W'(cfg.board_cols);

    always_comb
    begin
        if (rows_ext < RCMP_W'(2))
            last_row_w = RCMP_W'(1);
        else if (rows_ext > MAX_ROWS_C)
            last_row_w = MAX_ROWS_C - RCMP_W'(1);
        else
            last_row_w = rows_ext - RCMP_W'(1);

        if (cols_ext < CCMP_W'(2))
            last_col_w = CCMP_W'(1);
        else if (cols_ext > MAX_COLS_C)
            last_col_w = MAX_COLS_C - CCMP_W'(1);
        else
            last_col_w = cols_ext - CCMP_W'(1);
    end

    assign last_row = last_row_w[ROW_W-1:0];
    assign last_col = last_col_w[COL_W-1:0];

    // start position held inside the board
    assign srow_ext     = RS_W'(cfg.start_row);
    assign lrow_ext     = RS_W'(last_row);
    assign scol_ext     = CS_W'(cfg.start_col);
    assign lcol_ext     = CS_W'(last_col);
    assign start_row_cl = (srow_ext > lrow_ext) ? last_row : srow_ext[ROW_W-1:0];
    assign start_col_cl = (scol_ext > lcol_ext) ? last_col : scol_ext[COL_W-1:0];

    // current position held inside the board (the board may have shrunk)
    assign row_cl = (row_reg > last_row) ? last_row : row_reg;
    assign col_cl = (col_reg > last_col) ? last_col : col_reg;

    // turn on the cell color read back, then bounce off the edge
    assign dir_turn = ram_rd_data ? (dir_reg - 2'd1) : (dir_reg + 2'd1);
    assign at_edge  = ((dir_turn == lant_pkg::HEAD_UP)    && (row_reg == '0))      ||
                      ((dir_turn == lant_pkg::HEAD_DOWN)  && (row_reg == last_row)) ||
                      ((dir_turn == lant_pkg::HEAD_LEFT)  && (col_reg == '0))      ||
                      ((dir_turn == lant_pkg::HEAD_RIGHT) && (col_reg == last_col));
    assign dir_mv   = at_edge ? (dir_turn + 2'd2) : dir_turn;

    always_comb
    begin
        row_mv = row_reg;
        col_mv = col_reg;
        unique case (dir_mv)
            lant_pkg::HEAD_UP:    row_mv = row_reg - ROW_W'(1);
            lant_pkg::HEAD_RIGHT: col_mv = col_reg + COL_W'(1);
            lant_pkg::HEAD_DOWN:  row_mv = row_reg + ROW_W'(1);
            default:              col_mv = col_reg - COL_W'(1);
        endcase
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lant_pkg::ST_IDLE) ||
                       ((state_reg == lant_pkg::ST_EMIT) && out_free);
    assign accept    = in_valid && in_ready;
    assign limit_hit = step_reg >= cfg.step_limit;
    assign clr_last  = &clr_addr_reg;

    assign row_wide = (ROW_W + lant_pkg::POS_W)'(row_reg);
    assign col_wide = (COL_W + lant_pkg::POS_W)'(col_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lant_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = clr_emit_reg ? lant_pkg::ST_EMIT : lant_pkg::ST_IDLE;
            end
            lant_pkg::ST_IDLE, lant_pkg::ST_EMIT:
            begin
                if (accept)
                begin
                    if (in_restart)
                        state_next = lant_pkg::ST_CLEAR;
                    else if (limit_hit)
                        state_next = lant_pkg::ST_EMIT;
                    else
                        state_next = lant_pkg::ST_MOVE;
                end
                else if (state_reg == lant_pkg::ST_EMIT && out_free)
                begin
                    state_next = lant_pkg::ST_IDLE;
                end
            end
            lant_pkg::ST_MOVE:
                state_next = lant_pkg::ST_EMIT;
            default:
                state_next = lant_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        dir_next         = dir_reg;
        step_next        = step_reg;
        done_next        = done_reg;
        fresh_next       = fresh_reg;
        clr_emit_next    = clr_emit_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_heading_next = out_heading_reg;
        out_under_next   = out_under_reg;
        out_step_next    = out_step_reg;
        out_done_next    = out_done_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = {row_reg, col_reg};
        ram_wr_data      = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = {row_reg, col_reg};

        unique case (state_reg)
            lant_pkg::ST_CLEAR:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = 1'b0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            lant_pkg::ST_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = {row_reg, col_reg};
                ram_wr_data = !ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = {row_mv, col_mv};
                row_next    = row_mv;
                col_next    = col_mv;
                dir_next    = dir_mv;
                step_next   = step_reg + lant_pkg::STEP_W'(1);
                done_next   = 1'b0;
                fresh_next  = 1'b0;
            end
            default:
            begin
            end
        endcase

        // result register load; read data is still the cell under the ant here
        if (state_reg == lant_pkg::ST_EMIT && out_free)
        begin
            out_valid_next   = 1'b1;
            out_row_next     = row_wide[lant_pkg::POS_W-1:0];
            out_col_next     = col_wide[lant_pkg::POS_W-1:0];
            out_heading_next = dir_reg;
            out_under_next   = fresh_reg ? 1'b0 : ram_rd_data;
            out_step_next    = step_reg;
            out_done_next    = done_reg;
        end

        if (accept)
        begin
            if (in_restart)
            begin
                row_next      = start_row_cl;
                col_next      = start_col_cl;
                dir_next      = cfg.start_heading;
                step_next     = '0;
                done_next     = 1'b0;
                fresh_next    = 1'b1;
                clr_emit_next = 1'b1;
                clr_addr_next = '0;
            end
            else if (limit_hit)
            begin
                // report the unchanged state
                ram_rd_en   = 1'b1;
                ram_rd_addr = {row_reg, col_reg};
                done_next   = 1'b1;
                fresh_next  = 1'b0;
            end
            else
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = {row_cl, col_cl};
                row_next    = row_cl;
                col_next    = col_cl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lant_pkg::ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            dir_reg       <= lant_pkg::HEAD_UP;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            clr_emit_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            dir_reg       <= dir_next;
            step_reg      <= step_next;
            done_reg      <= done_next;
            fresh_reg     <= fresh_next;
            clr_emit_reg  <= clr_emit_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_heading_reg <= out_heading_next;
        out_under_reg   <= out_under_next;
        out_step_reg    <= out_step_next;
        out_done_reg    <= out_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_heading = out_heading_reg;
    assign out_under   = out_under_reg;
    assign out_step    = out_step_reg;
    assign out_done    = out_done_reg;

endmodule

// ----- design/langton_ant_grid_stepper.sv -----
// Top level of the Langton's ant grid stepper.
//
// Langton's ant on a bounded grid of one-bit cells, held in a single-port-write,
// single-port-read RAM of 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells addressed
// as {row, col}. Each input item is either a restart (tdata bit 0 high) or a
// tick. On acceptance a tick reads the cell under the ant; in the move state it
// turns the ant, writes the flipped color back, moves it and reads the color of
// the cell it lands on; the result register then loads in the emit state once
// the output register is free, and the next item can be taken in that same
// cycle, so ticks do not overlap. A tick at or past step_limit is reported
// with done set (tuser) and changes nothing; it goes straight to the emit
// state, where its result loads once the output register is free. A restart
// clears the whole cell RAM one cell a cycle, then its result loads in the emit
// state. After reset the same clearing pass runs with s_axis_tready low;
// configuration writes are taken at any time, cfg_ready is always high.
// Registers should be written only while no item is in flight. A result waits
// in an output register, and the next item is taken while it waits.
module langton_ant_grid_stepper
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lant_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] restart
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] ant_row, [11:6] ant_col, [13:12] heading, [14] under_color,
    // [34:15] step_number, [39:35] zero
    output logic [lant_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] done_res
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lant_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lant_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
    localparam int PAD_W  = lant_pkg::OUT_DATA_W - 2 * lant_pkg::POS_W - lant_pkg::HEAD_W
                            - 1 - lant_pkg::STEP_W;

    lant_pkg::cfg_t cfg;

    logic                        ram_wr_en;
    logic [ADDR_W-1:0]           ram_wr_addr;
    logic                        ram_wr_data;
    logic                        ram_rd_en;
    logic [ADDR_W-1:0]           ram_rd_addr;
    logic                        ram_rd_data;

    logic [lant_pkg::POS_W-1:0]  ant_row;
    logic [lant_pkg::POS_W-1:0]  ant_col;
    logic [lant_pkg::HEAD_W-1:0] heading;
    logic                        under_color;
    logic [lant_pkg::STEP_W-1:0] step_number;
    logic                        done_res;

    lant_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lant_cell_ram #(.ADDR_W(ADDR_W)) u_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lant_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_restart  (s_axis_tdata[0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_row     (ant_row),
        .out_col     (ant_col),
        .out_heading (heading),
        .out_under   (under_color),
        .out_step    (step_number),
        .out_done    (done_res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {{PAD_W{1'b0}}, step_number, under_color, heading, ant_col, ant_row};
    assign m_axis_tuser = done_res;

endmodule

// ----- test/tb_langton_ant_grid_stepper.sv -----
// Self-checking testbench for the Langton's ant grid stepper.
`timescale 1ns / 1ps

module tb_langton_ant_grid_stepper;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam logic [lant_pkg::STEP_W-1:0] STEP_MAX = 20'hFFFFF;
    // no register sits at this index; writes to it must change nothing
    localparam logic [lant_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    // restarts clear 4096 cells each, so the run is dominated by them
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEMS_PER_PHASE = 625;
    localparam int PLAN_LEN = 41;

    // one result item, fields in the order they sit in tdata / tuser
    typedef struct packed {
        logic [lant_pkg::POS_W-1:0]  row;
        logic [lant_pkg::POS_W-1:0]  col;
        logic [lant_pkg::HEAD_W-1:0] heading;
        logic                        color;
        logic [lant_pkg::STEP_W-1:0] step;
        logic                        done;
    } ant_report_t;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

    // one row of the directed plan: a register write or an input item,
    // the item optionally carrying a hand-typed expected report
    typedef struct packed {
        row_kind_t                       kind;
        logic [lant_pkg::CFG_ADDR_W-1:0] addr;
        logic [lant_pkg::CFG_DATA_W-1:0] data;
        logic                            restart;
        logic                            typed;
        ant_report_t                     report;
    } plan_row_t;

    localparam ant_report_t NONE = '0;

    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // step limit is zero out of reset: a tick changes nothing and is flagged done
        '{ROW_ITEM, '0, '0, 1'b0, 1'b1, '{6'd0, 6'd0, lant_pkg::HEAD_UP, 1'b0, 20'd0, 1'b1}},
        '{ROW_ITEM, '0, '0, 1'b1, 1'b1, '{6'd0, 6'd0, lant_pkg::HEAD_UP, 1'b0, 20'd0, 1'b0}},
        // far corner, widest limit
        '{ROW_WRITE, lant_pkg::REG_STEP_LIMIT, STEP_MAX, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_ROW, 20'd63, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_COL, 20'd63, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_HEADING, 20'(lant_pkg::HEAD_RIGHT), 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b1, 1'b1,
          '{6'd63, 6'd63, lant_pkg::HEAD_RIGHT, 1'b0, 20'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        // sizes out of range, board shrinks under the ant mid-run
        '{ROW_WRITE, lant_pkg::REG_BOARD_ROWS, 20'd0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_BOARD_COLS, 20'd127, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        // start row past the two-row board lands on the last row
        '{ROW_ITEM, '0, '0, 1'b1, 1'b1,
          '{6'd1, 6'd63, lant_pkg::HEAD_RIGHT, 1'b0, 20'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        // 2 x 2 board, junk above the register width, limit of three steps
        '{ROW_WRITE, lant_pkg::REG_BOARD_ROWS, 20'hFFF82, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_BOARD_COLS, 20'd1, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_ROW, 20'd0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_COL, 20'd0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_HEADING, 20'(lant_pkg::HEAD_LEFT), 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_STEP_LIMIT, 20'd3, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, REG_UNUSED, 20'hABCDE, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b1, 1'b1, '{6'd0, 6'd0, lant_pkg::HEAD_LEFT, 1'b0, 20'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE},
        // full board again, start on the bottom row facing down
        '{ROW_WRITE, lant_pkg::REG_BOARD_ROWS, 20'd64, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_BOARD_COLS, 20'd64, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_ROW, 20'd63, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, lant_pkg::REG_START_HEADING, 20'(lant_pkg::HEAD_DOWN), 1'b0, 1'b0, NONE},
        '{ROW_ITEM, '0, '0, 1'b1, 1'b1, '{6'd63, 6'd0, lant_pkg::HEAD_DOWN, 1'b0, 20'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, 1'b0, 1'b0, NONE}
    };

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lant_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [0] restart
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [5:0] ant_row, [11:6] ant_col, [13:12] heading, [14] under_color,
    // [34:15] step_number, [39:35] zero
    logic [lant_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;         // [0] done_res
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lant_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [lant_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    // predictor state: registers as the block should hold them, plus the ant
    lant_pkg::cfg_t              shadow_cfg = lant_pkg::CFG_RESET;
    bit                          cell_map [GRID_ROWS*GRID_COLS];
    int unsigned                 ant_row;
    int unsigned                 ant_col;
    logic [lant_pkg::HEAD_W-1:0] ant_dir;
    logic [lant_pkg::STEP_W-1:0] ant_steps;

    ant_report_t pending_reports [$];
    int          mismatches;
    int          sent_items;      // accepted input items
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;       // receiver hold-off, counted down below
    int          cycle_count;

    langton_ant_grid_stepper #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // board size in use: saturate to 2..hi
    function automatic int unsigned size_in_use(input int unsigned v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // one step of the ant; updates the predictor state and returns the report
    function automatic ant_report_t advance_ant(input logic restart_bit);
        int unsigned rows;
        int unsigned cols;
        int unsigned idx;
        ant_report_t rep;
        rows = size_in_use(shadow_cfg.board_rows, GRID_ROWS);
        cols = size_in_use(shadow_cfg.board_cols, GRID_COLS);
        rep.done = 1'b0;
        if (restart_bit)
        begin
            foreach (cell_map[i])
                cell_map[i] = 1'b0;
            ant_row   = (shadow_cfg.start_row > rows - 1) ? rows - 1 : shadow_cfg.start_row;
            ant_col   = (shadow_cfg.start_col > cols - 1) ? cols - 1 : shadow_cfg.start_col;
            ant_dir   = shadow_cfg.start_heading;
            ant_steps = '0;
        end
        else if (ant_steps >= shadow_cfg.step_limit)
            rep.done = 1'b1;   // limit reached: nothing moves
        else
        begin
            // board may have shrunk under the ant
            if (ant_row > rows - 1)
                ant_row = rows - 1;
            if (ant_col > cols - 1)
                ant_col = cols - 1;
            idx = ant_row * GRID_COLS + ant_col;
            // white turns right, black turns left; the cell flips either way
            ant_dir = cell_map[idx] ? ant_dir - 2'd1 : ant_dir + 2'd1;
            cell_map[idx] = !cell_map[idx];
            // facing the edge: turn around
            if ((ant_dir == lant_pkg::HEAD_UP    && ant_row == 0)        ||
                (ant_dir == lant_pkg::HEAD_DOWN  && ant_row == rows - 1) ||
                (ant_dir == lant_pkg::HEAD_LEFT  && ant_col == 0)        ||
                (ant_dir == lant_pkg::HEAD_RIGHT && ant_col == cols - 1))
                ant_dir = ant_dir + 2'd2;
            case (ant_dir)
                lant_pkg::HEAD_UP:    ant_row = ant_row - 1;
                lant_pkg::HEAD_RIGHT: ant_col = ant_col + 1;
                lant_pkg::HEAD_DOWN:  ant_row = ant_row + 1;
                default:              ant_col = ant_col - 1;
            endcase
            ant_steps = ant_steps + 1'b1;
        end
        rep.row     = ant_row[lant_pkg::POS_W-1:0];
        rep.col     = ant_col[lant_pkg::POS_W-1:0];
        rep.heading = ant_dir;
        rep.color   = cell_map[ant_row * GRID_COLS + ant_col];
        rep.step    = ant_steps;
        return rep;
    endfunction

    // value with random junk above its register width now and then
    function automatic logic [lant_pkg::CFG_DATA_W-1:0] with_noise(input int unsigned value,
                                                                   input int unsigned width);
        logic [lant_pkg::CFG_DATA_W-1:0] v;
        v = lant_pkg::CFG_DATA_W'(value);
        if ($urandom_range(3) == 0)
            v = v | lant_pkg::CFG_DATA_W'($urandom() << width);
        return v;
    endfunction

    // board size: mostly legal, extremes and out-of-range values mixed in
    function automatic int unsigned draw_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return $urandom_range(1);
        if (pick < 10)
            return $urandom_range(127, 65);
        if (pick < 20)
            return 2;
        if (pick < 30)
            return 64;
        return $urandom_range(64, 2);
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Register write; leaves cfg_valid high so writes can go back to back.
    // Called only with nothing in flight.
    task automatic write_reg(input logic [lant_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [lant_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (addr)
            lant_pkg::REG_BOARD_ROWS:
                shadow_cfg.board_rows    = data[lant_pkg::SIZE_W-1:0];
            lant_pkg::REG_BOARD_COLS:
                shadow_cfg.board_cols    = data[lant_pkg::SIZE_W-1:0];
            lant_pkg::REG_START_ROW:
                shadow_cfg.start_row     = data[lant_pkg::POS_W-1:0];
            lant_pkg::REG_START_COL:
                shadow_cfg.start_col     = data[lant_pkg::POS_W-1:0];
            lant_pkg::REG_START_HEADING:
                shadow_cfg.start_heading = data[lant_pkg::HEAD_W-1:0];
            lant_pkg::REG_STEP_LIMIT:
                shadow_cfg.step_limit    = data[lant_pkg::STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Offer one item after a random gap; valid stays high on return so the
    // next item can follow without a bubble.
    task automatic send_item(input logic restart_bit, input logic typed,
                             input ant_report_t typed_report);
        ant_report_t predicted;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(lant_pkg::IN_DATA_W-1){1'b0}}, restart_bit};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_ant(restart_bit);
        pending_reports.push_back(typed ? typed_report : predicted);
        sent_items++;
        @(negedge clk);
    endtask

    // sender pauses until every expected result has come back
    task automatic drain_results();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
    endtask

    // fresh settings for a run of ticks; every register gets written
    task automatic draw_board_setup(input int unsigned run_ticks);
        int unsigned rows_v;
        int unsigned cols_v;
        int unsigned pick;
        logic [lant_pkg::STEP_W-1:0] limit_v;
        rows_v = draw_size();
        cols_v = draw_size();
        write_reg(lant_pkg::REG_BOARD_ROWS, with_noise(rows_v, lant_pkg::SIZE_W));
        write_reg(lant_pkg::REG_BOARD_COLS, with_noise(cols_v, lant_pkg::SIZE_W));
        // start mostly on the board, sometimes past its edge
        write_reg(lant_pkg::REG_START_ROW, with_noise($urandom_range(99) < 75 ?
            $urandom_range(size_in_use(rows_v, GRID_ROWS) - 1) : $urandom_range(63),
            lant_pkg::POS_W));
        write_reg(lant_pkg::REG_START_COL, with_noise($urandom_range(99) < 75 ?
            $urandom_range(size_in_use(cols_v, GRID_COLS) - 1) : $urandom_range(63),
            lant_pkg::POS_W));
        write_reg(lant_pkg::REG_START_HEADING,
                  with_noise($urandom_range(3), lant_pkg::HEAD_W));
        pick = $urandom_range(99);
        if (pick < 8)
            limit_v = '0;
        else if (pick < 18)
            limit_v = STEP_MAX;
        else if (pick < 35)
            limit_v = lant_pkg::STEP_W'($urandom_range(run_ticks));   // run hits the limit
        else if (pick < 50)
            limit_v = lant_pkg::STEP_W'($urandom());
        else
            limit_v = lant_pkg::STEP_W'($urandom_range(STEP_MAX, run_ticks + 1));
        write_reg(lant_pkg::REG_STEP_LIMIT, limit_v);
        if ($urandom_range(9) == 0)
            write_reg(REG_UNUSED, lant_pkg::CFG_DATA_W'($urandom()));
    endtask

    // Receiver: random back-pressure, or a long hold-off when asked for.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        ant_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with none expected: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("ant_row",     want.row,     m_axis_tdata[5:0]);
                check_field("ant_col",     want.col,     m_axis_tdata[11:6]);
                check_field("heading",     want.heading, m_axis_tdata[13:12]);
                check_field("under_color", want.color,   m_axis_tdata[14]);
                check_field("step_number", want.step,    m_axis_tdata[34:15]);
                check_field("done_res",    want.done,    m_axis_tuser);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_langton_ant_grid_stepper failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned run_ticks;
        int          phase_goal;
        int          phase;
        int          t;
        int          i;

        mismatches    = 0;
        sent_items    = 0;
        hold_left     = 0;
        cycle_count   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 59;
        ant_row       = 0;
        ant_col       = 0;
        ant_dir       = lant_pkg::HEAD_UP;
        ant_steps     = '0;
        foreach (cell_map[k])
            cell_map[k] = 1'b0;

        // reset once; the block then clears its cell RAM with tready low
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed plan; writes wait for the block to go idle
        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (DIRECTED_PLAN[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIRECTED_PLAN[i].addr, DIRECTED_PLAN[i].data);
            end
            else
                send_item(DIRECTED_PLAN[i].restart, DIRECTED_PLAN[i].typed,
                          DIRECTED_PLAN[i].report);
        end

        // random runs: receiver-heavy idling, then sender-heavy, then none
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 31 : 0;
            phase_goal    = sent_items + ITEMS_PER_PHASE;
            if (phase == 2)
            begin
                // long receiver hold-off while ticks keep coming: the output
                // register fills and the block must stall its input
                drain_results();
                write_reg(lant_pkg::REG_STEP_LIMIT, STEP_MAX);
                hold_left = 400;
                for (t = 0; t < 40; t++)
                    send_item(1'b0, 1'b0, NONE);
            end
            while (sent_items < phase_goal)
            begin
                run_ticks = $urandom_range(70, 10);
                drain_results();
                draw_board_setup(run_ticks);
                // usually a fresh run; otherwise the old ant meets new settings
                if ($urandom_range(99) < 85)
                    send_item(1'b1, 1'b0, NONE);
                for (t = 0; t < run_ticks; t++)
                begin
                    if (t == run_ticks / 2 && $urandom_range(99) < 15)
                    begin
                        // resize under a running ant
                        drain_results();
                        write_reg(lant_pkg::REG_BOARD_ROWS,
                                  lant_pkg::CFG_DATA_W'(draw_size()));
                        write_reg(lant_pkg::REG_BOARD_COLS,
                                  lant_pkg::CFG_DATA_W'(draw_size()));
                    end
                    send_item($urandom_range(199) == 0, 1'b0, NONE);
                end
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_langton_ant_grid_stepper passed");
        else
            $display("tb_langton_ant_grid_stepper failed");
        $finish;
    end

endmodule
